// ----- sv/rmss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rmss_pkg;

	localparam int CNT_W = 5;

	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_TICK  = 3'd1;
	localparam logic [2:0] OP_DONE  = 3'd2;
	localparam logic [2:0] OP_BUFWR = 3'd3;
	localparam logic [2:0] OP_RUN   = 3'd4;
	localparam logic [2:0] OP_STOP  = 3'd5;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] MODE_OFF      = 2'd0;
	localparam logic [1:0] MODE_WAITING  = 2'd1;
	localparam logic [1:0] MODE_SWEEPING = 2'd2;

	localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
	localparam logic [1:0] CFG_HEADER   = 2'd1;
	localparam logic [1:0] CFG_PERIOD   = 2'd2;
	localparam logic [1:0] CFG_COUNT    = 2'd3;

	localparam logic [15:0] PERIOD_RESET = 16'd33;
	localparam logic [7:0]  ERR_SAT      = 8'hff;
	localparam logic [8:0]  LEN_SAT      = 9'd511;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] entry_index;
		logic [7:0] entry_position;
		logic       entry_auto_place;
		logic [7:0] entry_length;
		logic       entry_is_write;
		logic       entry_regular;
		logic       transfer_ok;
		logic [7:0] write_position;
		logic [7:0] write_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0] issue_kind;
		logic [6:0] bus_address;
		logic [7:0] register_start;
		logic [8:0] transfer_length;
		logic       copy_valid;
		logic [7:0] copy_offset;
		logic [8:0] copy_length;
		logic [7:0] error_sweeps;
		logic [1:0] mode;
	} out_item_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_CAPTURE,
		CMD_LOAD,
		CMD_TICK,
		CMD_DONE,
		CMD_RUN,
		CMD_STOP,
		CMD_SCAN_NEXT,
		CMD_SCAN_EMPTY,
		CMD_RUN_OPEN,
		CMD_RUN_NEXT,
		CMD_ISSUE,
		CMD_J_NEXT,
		CMD_BW_MARK,
		CMD_PUBLISH
	} cmd_code_t;

	typedef enum logic [1:0] {
		SEL_PREV,
		SEL_CUR,
		SEL_J
	} rd_sel_t;

	typedef struct packed {
		cmd_code_t code;
		rd_sel_t   sel;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       tick_scan;
		logic       done_scan;
		logic       cur_lt_n;
		logic       cur_wanted;
		logic       j_lt_n;
		logic       run_match;
		logic       bw_below;
		logic       bw_in;
		logic       out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- sv/register_map_sync_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Register map sync scheduler. Each input beat is one event (load descriptor,
// tick, transfer done, buffer written, run, stop) and yields exactly one
// result beat carrying any bus request issued, any read copy to perform, the
// error-sweep count and the mode. One event is handled at a time: a tick or
// done that scans, or a buffer-written event, walks the descriptors one at a
// time through the single table read port of the datapath. Results wait in an
// output register, so a stalled result only delays the end of the next event.
// The user must write config only while idle; the block itself does not
// enforce it.
module register_map_sync_scheduler #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire rmss_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output rmss_pkg::out_item_t      out_data
);
	import rmss_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t st;

	// sequencer: walks the table one entry per cycle
	rmss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// table, scheduler state, config and result register
	rmss_dp #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.st        (st),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	// one event at a time: an accepted beat closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an event is in flight");

	// requests only come out of a sweep
	a_issue_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.issue_kind != KIND_NONE) |-> (out_data.mode == MODE_SWEEPING))
		else $error("request issued outside a sweep");

	// never an unknown request code
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.issue_kind != 2'd3))
		else $error("illegal issue kind");
`endif

endmodule
`default_nettype wire

// ----- sv/rmss_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rmss_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire rmss_pkg::dp_status_t st,
	output rmss_pkg::ctl_cmd_t      cmd
);
	import rmss_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_RUN,
		S_BW_SKIP,
		S_BW_MARK,
		S_PUBLISH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd.code = CMD_NOP;
		cmd.sel  = SEL_CUR;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.code = CMD_CAPTURE;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.sel = SEL_PREV;
				state_d = S_PUBLISH;
				case (st.op)
					OP_LOAD: cmd.code = CMD_LOAD;
					OP_TICK: begin
						cmd.code = CMD_TICK;
						if (st.tick_scan) state_d = S_SCAN;
					end
					OP_DONE: begin
						cmd.code = CMD_DONE;
						if (st.done_scan) state_d = S_SCAN;
					end
					OP_BUFWR: state_d = S_BW_SKIP;
					OP_RUN:   cmd.code = CMD_RUN;
					OP_STOP:  cmd.code = CMD_STOP;
					default:  cmd.code = CMD_NOP;
				endcase
			end
			S_SCAN: begin
				cmd.sel = SEL_CUR;
				if (!st.cur_lt_n) begin
					cmd.code = CMD_SCAN_EMPTY;
					state_d  = S_PUBLISH;
				end else if (!st.cur_wanted) begin
					cmd.code = CMD_SCAN_NEXT;
				end else begin
					cmd.code = CMD_RUN_OPEN;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				cmd.sel = SEL_J;
				if (st.run_match) begin
					cmd.code = CMD_RUN_NEXT;
				end else begin
					cmd.code = CMD_ISSUE;
					state_d  = S_PUBLISH;
				end
			end
			S_BW_SKIP: begin
				cmd.sel = SEL_J;
				if (st.j_lt_n && st.bw_below) cmd.code = CMD_J_NEXT;
				else state_d = S_BW_MARK;
			end
			S_BW_MARK: begin
				cmd.sel = SEL_J;
				if (st.j_lt_n && st.bw_in) cmd.code = CMD_BW_MARK;
				else state_d = S_PUBLISH;
			end
			S_PUBLISH: begin
				if (st.out_free) begin
					cmd.code = CMD_PUBLISH;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			in_stall <= 1'b0;
		end else begin
			state_q  <= state_d;
			in_stall <= (state_d != S_IDLE);
		end
	end

endmodule
`default_nettype wire

// ----- sv/rmss_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rmss_dp #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire rmss_pkg::in_item_t  in_data,
	input  wire rmss_pkg::ctl_cmd_t  cmd,
	output rmss_pkg::dp_status_t     st,
	input  wire logic                out_stall,
	output logic                     out_valid,
	output rmss_pkg::out_item_t      out_data
);
	import rmss_pkg::*;

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OUT_W = $bits(out_item_t);

	// descriptor table, no reset
	logic [7:0] pos_q  [MAX_ENTRIES];
	logic [7:0] len_q  [MAX_ENTRIES];
	logic       wr_q   [MAX_ENTRIES];
	logic       reg_q  [MAX_ENTRIES];
	logic       pend_q [MAX_ENTRIES];

	logic [6:0]       dev_q;
	logic [3:0]       hdr_q;
	logic [15:0]      period_q;
	logic [CNT_W-1:0] count_q;

	logic [1:0]       mode_q;
	logic [CNT_W-1:0] cur_q;
	logic             err_q;
	logic [7:0]       failed_q;
	logic [1:0]       outst_q;
	logic [7:0]       rd_off_q;
	logic [8:0]       rd_len_q;
	logic [15:0]      cdown_q;

	in_item_t         item_q;
	logic [CNT_W-1:0] j_q;
	logic [7:0]       first_pos_q;
	logic [8:0]       end_q;
	logic [8:0]       last_end_q;
	logic             dir_q;
	out_item_t        res_q;

	logic [CNT_W-1:0] n;
	logic [IW-1:0]    rd_idx;
	logic [IW-1:0]    ld_idx;
	logic [7:0]       e_pos;
	logic [7:0]       e_len;
	logic             e_wr;
	logic             e_wanted;
	logic [8:0]       e_end;
	logic             slot_ok;
	logic [7:0]       ld_pos;
	logic [8:0]       run_size;
	logic [9:0]       rd_total;
	logic             do_ld;
	logic             do_clr;
	logic             do_mark;

	assign n = (32'(count_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : count_q;

	always_comb begin
		case (cmd.sel)
			SEL_PREV: rd_idx = IW'(item_q.entry_index - 4'd1);
			SEL_J:    rd_idx = IW'(j_q);
			default:  rd_idx = IW'(cur_q);
		endcase
	end

	assign ld_idx   = IW'(item_q.entry_index);
	assign e_pos    = pos_q[rd_idx];
	assign e_len    = len_q[rd_idx];
	assign e_wr     = wr_q[rd_idx];
	assign e_wanted = pend_q[rd_idx] | reg_q[rd_idx];
	assign e_end    = {1'b0, e_pos} + {1'b0, e_len};
	assign slot_ok  = 32'(item_q.entry_index) < MAX_ENTRIES;

	always_comb begin
		if (!item_q.entry_auto_place) ld_pos = item_q.entry_position;
		else if (item_q.entry_index == 4'd0) ld_pos = 8'd0;
		else ld_pos = e_end[7:0];
	end

	assign run_size = last_end_q - {1'b0, first_pos_q};
	assign rd_total = {1'b0, run_size} + {6'd0, hdr_q};

	assign st.op         = item_q.op;
	assign st.tick_scan  = (cdown_q <= 16'd1) && (mode_q != MODE_OFF) && (outst_q == KIND_NONE);
	assign st.done_scan  = (outst_q != KIND_NONE) && (mode_q == MODE_SWEEPING);
	assign st.cur_lt_n   = cur_q < n;
	assign st.cur_wanted = e_wanted;
	assign st.j_lt_n     = j_q < n;
	assign st.run_match  = (j_q < n) && (e_wr == dir_q) && ({1'b0, e_pos} == end_q) && e_wanted;
	assign st.bw_below   = e_pos < item_q.write_position;
	assign st.bw_in      = {1'b0, e_pos} <=
		({1'b0, item_q.write_position} + {1'b0, item_q.write_length});
	assign st.out_free   = !out_valid || !out_stall;

	assign do_ld   = (cmd.code == CMD_LOAD) && slot_ok;
	assign do_clr  = (cmd.code == CMD_RUN_OPEN) || (cmd.code == CMD_RUN_NEXT);
	assign do_mark = (cmd.code == CMD_BW_MARK) && e_wr;

	always_ff @(posedge clk) begin
		if (do_ld) begin
			pos_q[ld_idx]  <= ld_pos;
			len_q[ld_idx]  <= item_q.entry_length;
			wr_q[ld_idx]   <= item_q.entry_is_write;
			reg_q[ld_idx]  <= item_q.entry_regular;
			pend_q[ld_idx] <= 1'b1;
		end else if (do_clr) begin
			pend_q[rd_idx] <= 1'b0;
		end else if (do_mark) begin
			pend_q[rd_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q    <= '0;
			hdr_q    <= '0;
			period_q <= PERIOD_RESET;
			count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEV_ADDR: dev_q    <= cfg_data[6:0];
				CFG_HEADER:   hdr_q    <= cfg_data[3:0];
				CFG_PERIOD:   period_q <= cfg_data;
				CFG_COUNT:    count_q  <= cfg_data[CNT_W-1:0];
				default:      dev_q    <= dev_q;
			endcase
		end
	end

	// working registers of one item
	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_CAPTURE: begin
				item_q <= in_data;
				j_q    <= '0;
				res_q  <= '0;
			end
			CMD_DONE: begin
				if (outst_q == KIND_READ && item_q.transfer_ok) begin
					res_q.copy_valid  <= 1'b1;
					res_q.copy_offset <= rd_off_q;
					res_q.copy_length <= rd_len_q;
				end
			end
			CMD_RUN_OPEN: begin
				first_pos_q <= e_pos;
				end_q       <= e_end;
				last_end_q  <= e_end;
				dir_q       <= e_wr;
				j_q         <= cur_q + CNT_W'(1);
			end
			CMD_RUN_NEXT: begin
				last_end_q <= e_end;
				j_q        <= j_q + CNT_W'(1);
			end
			CMD_ISSUE: begin
				res_q.issue_kind     <= dir_q ? KIND_WRITE : KIND_READ;
				res_q.bus_address    <= dev_q;
				res_q.register_start <= first_pos_q;
				if (dir_q) res_q.transfer_length <= run_size;
				else if (rd_total > 10'(LEN_SAT)) res_q.transfer_length <= LEN_SAT;
				else res_q.transfer_length <= rd_total[8:0];
			end
			CMD_J_NEXT, CMD_BW_MARK: j_q <= j_q + CNT_W'(1);
			default: j_q <= j_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_OFF;
			cur_q     <= '0;
			err_q     <= 1'b0;
			failed_q  <= '0;
			outst_q   <= KIND_NONE;
			rd_off_q  <= '0;
			rd_len_q  <= '0;
			cdown_q   <= PERIOD_RESET;
			out_valid <= 1'b0;
		end else begin
			if (cmd.code == CMD_PUBLISH) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (cmd.code)
				CMD_TICK: begin
					if (cdown_q <= 16'd1) begin
						cdown_q <= period_q;
						if (mode_q != MODE_OFF) begin
							mode_q <= MODE_SWEEPING;
							err_q  <= 1'b0;
							cur_q  <= '0;
						end
					end else begin
						cdown_q <= cdown_q - 16'd1;
					end
				end
				CMD_DONE: begin
					if (outst_q != KIND_NONE) begin
						outst_q <= KIND_NONE;
						if (mode_q == MODE_SWEEPING && !item_q.transfer_ok && !err_q) begin
							err_q <= 1'b1;
							if (failed_q != ERR_SAT) failed_q <= failed_q + 8'd1;
						end
					end
				end
				CMD_RUN:        mode_q <= MODE_WAITING;
				CMD_STOP:       mode_q <= MODE_OFF;
				CMD_SCAN_NEXT:  cur_q  <= cur_q + CNT_W'(1);
				CMD_SCAN_EMPTY: begin
					mode_q <= MODE_WAITING;
					if (!err_q) failed_q <= '0;
				end
				CMD_ISSUE: begin
					cur_q   <= j_q;
					outst_q <= dir_q ? KIND_WRITE : KIND_READ;
					if (!dir_q) begin
						rd_off_q <= first_pos_q;
						rd_len_q <= run_size;
					end
				end
				default:     cur_q     <= cur_q;
			endcase
		end
	end

	// error count and mode sit in the low ten bits of the result
	always_ff @(posedge clk) begin
		if (cmd.code == CMD_PUBLISH) begin
			out_data <= {res_q[OUT_W-1:10], failed_q, mode_q};
		end
	end

endmodule
`default_nettype wire
